// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the BMP stream decoder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define BMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every clock edge, reset included.
`define BMP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/bmp24_pkg.sv -----
// ----------------------------------------------------------------------------
// BMP24 decoder package
// Types, codes and limits shared by the decoder and its checker.
// ----------------------------------------------------------------------------
package bmp24_pkg;

  // Largest image the decoder accepts.
  localparam int unsigned MAX_WIDTH  = 4096;
  localparam int unsigned MAX_HEIGHT = 4096;

  // Field widths of the result word.
  localparam int unsigned DIM_W  = 13;
  localparam int unsigned POS_W  = 12;
  localparam int unsigned HIDX_W = 6;

  // Result word layout, lowest bit first: red, green, blue, row, column,
  // width, height, error code, then zero fill to 80 bits.
  localparam int unsigned OUT_DATA_W = 80;
  localparam int unsigned ERR_LSB    = 74;

  // Parse modes.
  typedef enum logic [1:0] {
    MODE_HEADER = 2'd0,
    MODE_PIXEL  = 2'd1,
    MODE_PAD    = 2'd2,
    MODE_DONE   = 2'd3
  } mode_t;

  // Result kinds.
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_BAD_B     = 3'd0;
  localparam logic [2:0] ERR_BAD_M     = 3'd1;
  localparam logic [2:0] ERR_SIZE      = 3'd2;
  localparam logic [2:0] ERR_OFFSET    = 3'd3;
  localparam logic [2:0] ERR_INFO_SIZE = 3'd4;
  localparam logic [2:0] ERR_TOO_LARGE = 3'd5;

  // Header byte positions that carry a check or a capture.
  localparam logic [HIDX_W-1:0] HDR_SIG_B     = 6'd0;
  localparam logic [HIDX_W-1:0] HDR_SIG_M     = 6'd1;
  localparam logic [HIDX_W-1:0] HDR_FILE_SIZE = 6'd5;
  localparam logic [HIDX_W-1:0] HDR_OFFSET    = 6'd13;
  localparam logic [HIDX_W-1:0] HDR_INFO_SIZE = 6'd17;
  localparam logic [HIDX_W-1:0] HDR_WIDTH     = 6'd21;
  localparam logic [HIDX_W-1:0] HDR_HEIGHT    = 6'd25;
  localparam logic [HIDX_W-1:0] HDR_LAST      = 6'd53;

  localparam logic [7:0]  CHAR_B        = 8'h42;
  localparam logic [7:0]  CHAR_M        = 8'h4D;
  localparam logic [31:0] INFO_HDR_SIZE = 32'd40;

  // Positive as a signed 32-bit value.
  function automatic logic word_positive(input logic [31:0] w);
    word_positive = (w != 32'd0) && !w[31];
  endfunction

endpackage

// ----- hdl/bmp24_stream_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// BMP24 stream decoder
// Parses a 24-bit BMP file arriving one byte per word and emits RGB pixels.
// ----------------------------------------------------------------------------
//
//  Channel | Ports                 | Word contents
//  --------+-----------------------+---------------------------------------
//  in      | in_tvalid/tready      | tdata: file byte; tuser: start of file
//  out     | out_tvalid/tready     | tdata: pixel, position, size, error;
//          |                       | tuser: kind; tlast: last pixel
//
// Every input word is handled in the cycle it is accepted: the parse state
// and the result register load at the same edge, so one byte per cycle is
// sustained unless the output stalls; a result is offered in the cycle after
// its byte. The result register parts the two sides: a new byte is taken
// while the output is empty or being taken in the same cycle.
// Reset (rst_n low, synchronous) puts the parser in header mode at byte 0.
// An error or the last pixel parks the parser until the next start of file.
//
module bmp24_stream_decoder_unit import bmp24_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input byte stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] data_byte
  input  logic [0:0]            in_tuser,   // [0] start_of_file
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [7:0] red, [15:8] green,
                                            // [23:16] blue, [35:24] row,
                                            // [47:36] column, [60:48] width,
                                            // [73:61] height,
                                            // [76:74] error_code, rest zero
  output logic [1:0]            out_tuser,  // [1:0] kind
  output logic                  out_tlast   // last_pixel
);

  // Parse state.
  mode_t             mode_r,     mode_nxt;
  logic [HIDX_W-1:0] hidx_r,     hidx_nxt;
  logic [31:0]       shift_r,    shift_nxt;
  logic [DIM_W-1:0]  width_r,    width_nxt;
  logic [DIM_W-1:0]  height_r,   height_nxt;
  logic              wbig_r,     wbig_nxt;   // captured width beyond limit
  logic              hbig_r,     hbig_nxt;   // captured height beyond limit
  logic [POS_W-1:0]  row_r,      row_nxt;
  logic [POS_W-1:0]  col_r,      col_nxt;
  logic [1:0]        bip_r,      bip_nxt;    // byte within pixel
  logic [1:0]        pad_amt_r,  pad_amt_nxt;
  logic [1:0]        pad_cnt_r,  pad_cnt_nxt;
  logic [7:0]        blue_r,     blue_nxt;
  logic [7:0]        green_r,    green_nxt;

  // Result register.
  logic              out_valid_r;
  logic [1:0]        kind_r,     kind_nxt;
  logic [7:0]        red_r,      red_nxt;
  logic [7:0]        ogreen_r,   ogreen_nxt;
  logic [7:0]        oblue_r,    oblue_nxt;
  logic [POS_W-1:0]  orow_r,     orow_nxt;
  logic [POS_W-1:0]  ocol_r,     ocol_nxt;
  logic [DIM_W-1:0]  owidth_r,   owidth_nxt;
  logic [DIM_W-1:0]  oheight_r,  oheight_nxt;
  logic              olast_r,    olast_nxt;
  logic [2:0]        oerr_r,     oerr_nxt;
  logic              res_valid;

  logic              accept;
  logic              sof;
  logic [7:0]        din;
  logic [31:0]       shifted;
  logic [DIM_W-1:0]  col_inc;
  logic [DIM_W-1:0]  row_inc;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign sof       = in_tuser[0];
  assign din       = in_tdata;

  // Next parse state and result for the byte on the input.
  always_comb begin
    // A start of file restarts the parse before this byte is looked at.
    mode_nxt    = sof ? MODE_HEADER : mode_r;
    hidx_nxt    = sof ? '0 : hidx_r;
    shift_nxt   = sof ? '0 : shift_r;
    width_nxt   = sof ? '0 : width_r;
    height_nxt  = sof ? '0 : height_r;
    wbig_nxt    = sof ? 1'b0 : wbig_r;
    hbig_nxt    = sof ? 1'b0 : hbig_r;
    row_nxt     = sof ? '0 : row_r;
    col_nxt     = sof ? '0 : col_r;
    bip_nxt     = sof ? '0 : bip_r;
    pad_amt_nxt = sof ? '0 : pad_amt_r;
    pad_cnt_nxt = sof ? '0 : pad_cnt_r;
    blue_nxt    = sof ? '0 : blue_r;
    green_nxt   = sof ? '0 : green_r;

    res_valid   = 1'b0;
    kind_nxt    = KIND_PIXEL;
    red_nxt     = '0;
    ogreen_nxt  = '0;
    oblue_nxt   = '0;
    orow_nxt    = '0;
    ocol_nxt    = '0;
    owidth_nxt  = '0;
    oheight_nxt = '0;
    olast_nxt   = 1'b0;
    oerr_nxt    = '0;

    shifted = {din, shift_nxt[31:8]};
    col_inc = {1'b0, col_nxt} + DIM_W'(1);
    row_inc = {1'b0, row_nxt} + DIM_W'(1);

    case (mode_nxt)
      MODE_HEADER: begin
        shift_nxt = shifted;
        hidx_nxt  = hidx_nxt + HIDX_W'(1);
        case (hidx_nxt - HIDX_W'(1))
          HDR_SIG_B: begin
            if (din != CHAR_B) begin
              res_valid = 1'b1;
              kind_nxt  = KIND_ERROR;
              oerr_nxt  = ERR_BAD_B;
            end
          end
          HDR_SIG_M: begin
            if (din != CHAR_M) begin
              res_valid = 1'b1;
              kind_nxt  = KIND_ERROR;
              oerr_nxt  = ERR_BAD_M;
            end
          end
          HDR_FILE_SIZE: begin
            if (!word_positive(shifted)) begin
              res_valid = 1'b1;
              kind_nxt  = KIND_ERROR;
              oerr_nxt  = ERR_SIZE;
            end
          end
          HDR_OFFSET: begin
            if (!word_positive(shifted)) begin
              res_valid = 1'b1;
              kind_nxt  = KIND_ERROR;
              oerr_nxt  = ERR_OFFSET;
            end
          end
          HDR_INFO_SIZE: begin
            if (shifted != INFO_HDR_SIZE) begin
              res_valid = 1'b1;
              kind_nxt  = KIND_ERROR;
              oerr_nxt  = ERR_INFO_SIZE;
            end
          end
          HDR_WIDTH: begin
            // Only a positive word counts; anything else is an empty image.
            // The low bits are kept for any positive value; a flag marks one beyond the limit.
            if (word_positive(shifted)) begin
              width_nxt = shifted[DIM_W-1:0];
              wbig_nxt  = (shifted[30:0] > 31'(MAX_WIDTH));
            end else begin
              width_nxt = '0;
              wbig_nxt  = 1'b0;
            end
          end
          HDR_HEIGHT: begin
            if (word_positive(shifted)) begin
              height_nxt = shifted[DIM_W-1:0];
              hbig_nxt   = (shifted[30:0] > 31'(MAX_HEIGHT));
            end else begin
              height_nxt = '0;
              hbig_nxt   = 1'b0;
            end
          end
          HDR_LAST: begin
            res_valid = 1'b1;
            if (wbig_nxt || hbig_nxt) begin
              kind_nxt = KIND_ERROR;
              oerr_nxt = ERR_TOO_LARGE;
            end else begin
              // Rows are padded to 32 bits; 3*w bytes need (w mod 4) more.
              pad_amt_nxt = width_nxt[1:0];
              kind_nxt    = KIND_HEADER;
              owidth_nxt  = width_nxt;
              oheight_nxt = height_nxt;
              mode_nxt    = (width_nxt == '0 || height_nxt == '0) ? MODE_DONE
                                                                  : MODE_PIXEL;
            end
          end
          default: begin
          end
        endcase
        if (res_valid && kind_nxt == KIND_ERROR) begin
          mode_nxt = MODE_DONE;
        end
      end

      MODE_PIXEL: begin
        case (bip_nxt)
          2'd0: begin
            blue_nxt = din;
            bip_nxt  = 2'd1;
          end
          2'd1: begin
            green_nxt = din;
            bip_nxt   = 2'd2;
          end
          default: begin
            // Third byte is red: the pixel is complete.
            bip_nxt    = 2'd0;
            res_valid  = 1'b1;
            kind_nxt   = KIND_PIXEL;
            red_nxt    = din;
            ogreen_nxt = green_nxt;
            oblue_nxt  = blue_nxt;
            orow_nxt   = row_nxt;
            ocol_nxt   = col_nxt;
            if (col_inc >= width_nxt) begin
              if (row_inc >= height_nxt) begin
                olast_nxt = 1'b1;
                mode_nxt  = MODE_DONE;
              end else begin
                col_nxt = '0;
                row_nxt = row_inc[POS_W-1:0];
                if (pad_amt_nxt != 2'd0) begin
                  pad_cnt_nxt = 2'd0;
                  mode_nxt    = MODE_PAD;
                end
              end
            end else begin
              col_nxt = col_inc[POS_W-1:0];
            end
          end
        endcase
      end

      MODE_PAD: begin
        pad_cnt_nxt = pad_cnt_nxt + 2'd1;
        if (pad_cnt_nxt >= pad_amt_nxt) begin
          mode_nxt = MODE_PIXEL;
        end
      end

      default: begin
        // Done: bytes are dropped until the next start of file.
      end
    endcase
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_HEADER;
      hidx_r    <= '0;
      shift_r   <= '0;
      width_r   <= '0;
      height_r  <= '0;
      wbig_r    <= 1'b0;
      hbig_r    <= 1'b0;
      row_r     <= '0;
      col_r     <= '0;
      bip_r     <= '0;
      pad_amt_r <= '0;
      pad_cnt_r <= '0;
      blue_r    <= '0;
      green_r   <= '0;
    end else if (accept) begin
      mode_r    <= mode_nxt;
      hidx_r    <= hidx_nxt;
      shift_r   <= shift_nxt;
      width_r   <= width_nxt;
      height_r  <= height_nxt;
      wbig_r    <= wbig_nxt;
      hbig_r    <= hbig_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      bip_r     <= bip_nxt;
      pad_amt_r <= pad_amt_nxt;
      pad_cnt_r <= pad_cnt_nxt;
      blue_r    <= blue_nxt;
      green_r   <= green_nxt;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload; loads only when the register is free or being drained.
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      kind_r    <= kind_nxt;
      red_r     <= red_nxt;
      ogreen_r  <= ogreen_nxt;
      oblue_r   <= oblue_nxt;
      orow_r    <= orow_nxt;
      ocol_r    <= ocol_nxt;
      owidth_r  <= owidth_nxt;
      oheight_r <= oheight_nxt;
      olast_r   <= olast_nxt;
      oerr_r    <= oerr_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {3'b000, oerr_r, oheight_r, owidth_r, ocol_r, orow_r,
                       oblue_r, ogreen_r, red_r};

endmodule

// ----- hdl/bmp24_checker.sv -----
// ----------------------------------------------------------------------------
// BMP24 decoder port checker
// Watches the decoder's ports and flags results that break its rules.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmp24_checker import bmp24_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser,
  input logic                  out_tlast
);

  // An error word has every pixel, position and size bit clear and a known code.
  logic err_fields_ok;

  assign err_fields_ok = (out_tdata[ERR_LSB-1:0] == '0) &&
                         (out_tdata[ERR_LSB+2:ERR_LSB] <= ERR_TOO_LARGE);

  // A stalled result word stays offered.
  `BMP_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")

  // With the result register empty, the input side is always open.
  `BMP_ASSERT(a_in_open, !out_tvalid |-> in_tready, "input blocked with empty output")

  // The last-pixel mark only rides on pixel words.
  `BMP_ASSERT(a_last_pixel, out_tvalid && out_tlast |-> out_tuser == KIND_PIXEL, "stray tlast")

  // Error words carry a known code and nothing else.
  `BMP_ASSERT(a_err_word, out_tvalid && out_tuser == KIND_ERROR |-> err_fields_ok, "bad error word")

  // No result can be pending right after reset.
  `BMP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind bmp24_stream_decoder_unit bmp24_checker u_bmp24_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
